// ===== hw/rtl/urd_pkg.sv =====
// Shared types, constants and the seven-segment lookup for the range display block.
`timescale 1ns / 1ps

package urd_pkg;

  // Field and register widths
  localparam int unsigned SCALE_W    = 10;
  localparam int unsigned TWIDTH_W   = 8;
  localparam int unsigned RANGE_W    = 10;
  localparam int unsigned Q_SHIFT    = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [RANGE_W-1:0]  RANGE_MAX     = 10'd1023;
  localparam logic [SCALE_W-1:0]  SCALE_RESET   = 10'd281;
  localparam logic [TWIDTH_W-1:0] TWIDTH_RESET  = 8'd10;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_SCALE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_WIDTH = 1'b1;

  // Measurement sequencer states
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_TRIG = 4'b0010,
    PH_RISE = 4'b0100,
    PH_FALL = 4'b1000
  } phase_e;

  // Input word: one time step of pin samples and ticks
  typedef struct packed {
    logic start_req;
    logic echo;
    logic count_tick;
    logic scan_tick;
  } urd_in_t;

  // Result word
  typedef struct packed {
    logic               trigger;
    logic [6:0]         segments;
    logic [3:0]         digit_enable;
    logic [RANGE_W-1:0] range;
    logic               range_valid;
  } urd_out_t;

  // Status from the measurement sequencer for one step
  typedef struct packed {
    logic trigger;
    logic hit;
  } urd_meas_t;

  // Seven-segment pattern of a decimal digit, bit0 is segment a
  function automatic logic [6:0] seg_lut(input logic [3:0] digit);
    logic [6:0] pat;
    case (digit)
      4'd0:    pat = 7'h3f;
      4'd1:    pat = 7'h06;
      4'd2:    pat = 7'h5b;
      4'd3:    pat = 7'h4f;
      4'd4:    pat = 7'h66;
      4'd5:    pat = 7'h6d;
      4'd6:    pat = 7'h7d;
      4'd7:    pat = 7'h07;
      4'd8:    pat = 7'h7f;
      4'd9:    pat = 7'h67;
      default: pat = 7'h00;
    endcase
    return pat;
  endfunction

endpackage

// ===== hw/rtl/ultrasonic_range_display.sv =====
// Top level of the ultrasonic ranging block with four-digit display scan.
`timescale 1ns / 1ps

// One input word is one time step of the echo pin, the start request and the
// two ticks, and each word gives exactly one result word. The block takes a
// word every clock cycle unless in_stall_o is high, and each word passes through
// the input register, width multiply stage, digit split stage and result
// register. The whole pipeline moves together and holds only while a result
// waits under out_stall_i, which is then passed back as in_stall_o.
// Configuration writes take effect at the next clock edge and are meant for
// when no measurement is in flight.

module ultrasonic_range_display import urd_pkg::*; #(
  parameter int unsigned TIMER_BITS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  urd_in_t               in_word_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output urd_out_t              out_word_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned PROD_W = TIMER_BITS + SCALE_W;

  logic [SCALE_W-1:0]  scale_q;
  logic [TWIDTH_W-1:0] twidth_q;
  logic                en;
  logic                step;
  logic [1:0]          dig_idx_q, dig_idx_d;

  // Stage 1: input register
  logic    s1_valid_q;
  urd_in_t s1_word_q;

  // Stage 2: sequencer status and raw product
  urd_meas_t          meas;
  logic [PROD_W-1:0]  product;
  logic               s2_valid_q;
  urd_meas_t          s2_meas_q;
  logic [PROD_W-1:0]  s2_prod_q;
  logic [1:0]         s2_idx_q;

  // Stage 3: range and decimal quotients
  logic [RANGE_W-1:0] stored_range_q;
  logic [PROD_W-1:0]  shifted;
  logic [RANGE_W-1:0] range_c;
  logic [17:0]        mul10;
  logic [15:0]        mul100;
  logic               s3_valid_q;
  urd_meas_t          s3_meas_q;
  logic [RANGE_W-1:0] s3_range_q;
  logic [6:0]         s3_q10_q;
  logic [3:0]         s3_q100_q;
  logic [1:0]         s3_idx_q;

  // Stage 4: digit select and result register
  logic [RANGE_W-1:0] ones_w;
  logic [6:0]         tens_w;
  logic [3:0]         hund;
  logic [3:0]         thou;
  logic [3:0]         digit;
  urd_out_t           res_d;
  logic               out_valid_q;
  urd_out_t           out_word_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= SCALE_RESET;
      twidth_q <= TWIDTH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RANGE_SCALE:   scale_q  <= cfg_wdata_i;
        CFG_TRIGGER_WIDTH: twidth_q <= cfg_wdata_i[TWIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline advances unless the result word is held
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;
  assign step       = en && s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      s1_word_q <= in_word_i;
    end
  end

  urd_ranger #(
    .TIMER_BITS (TIMER_BITS)
  ) u_ranger (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .word_i          (s1_word_q),
    .range_scale_i   (scale_q),
    .trigger_width_i (twidth_q),
    .meas_o          (meas),
    .product_o       (product)
  );

  // Display scan position advances on each scan tick
  assign dig_idx_d = s1_word_q.scan_tick ? (dig_idx_q + 2'd1) : dig_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dig_idx_q  <= '0;
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        dig_idx_q <= dig_idx_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_meas_q <= meas;
      s2_prod_q <= product;
      s2_idx_q  <= dig_idx_d;
    end
  end

  // Scale down, saturate, and keep the old range when no width was taken
  assign shifted = s2_prod_q >> Q_SHIFT;
  always_comb begin
    if (!s2_meas_q.hit) begin
      range_c = stored_range_q;
    end else if (shifted > PROD_W'(RANGE_MAX)) begin
      range_c = RANGE_MAX;
    end else begin
      range_c = shifted[RANGE_W-1:0];
    end
  end

  // Divide by 10 and 100 through reciprocal multiplies, exact up to 1023
  assign mul10  = 18'(range_c) * 18'd205;
  assign mul100 = 16'(range_c) * 16'd41;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_range_q <= '0;
      s3_valid_q     <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q;
      if (s2_valid_q && s2_meas_q.hit) begin
        stored_range_q <= range_c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_meas_q  <= s2_meas_q;
      s3_range_q <= range_c;
      s3_q10_q   <= mul10[17:11];
      s3_q100_q  <= mul100[15:12];
      s3_idx_q   <= s2_idx_q;
    end
  end

  // Remainders give the four decimal digits
  assign ones_w = s3_range_q - (RANGE_W'(s3_q10_q) << 3) - (RANGE_W'(s3_q10_q) << 1);
  assign tens_w = s3_q10_q - (7'(s3_q100_q) << 3) - (7'(s3_q100_q) << 1);
  assign hund   = (s3_q100_q >= 4'd10) ? (s3_q100_q - 4'd10) : s3_q100_q;
  assign thou   = {3'b000, (s3_q100_q >= 4'd10)};

  always_comb begin
    case (s3_idx_q)
      2'd0:    digit = ones_w[3:0];
      2'd1:    digit = tens_w[3:0];
      2'd2:    digit = hund;
      default: digit = thou;
    endcase
  end

  always_comb begin
    res_d.trigger      = s3_meas_q.trigger;
    res_d.segments     = seg_lut(digit);
    res_d.digit_enable = ~(4'b0001 << s3_idx_q);
    res_d.range        = s3_range_q;
    res_d.range_valid  = s3_meas_q.hit;
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_word_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== hw/rtl/urd_ranger.sv =====
// Trigger and echo measurement sequencer with the free-running echo timer.
`timescale 1ns / 1ps

module urd_ranger import urd_pkg::*; #(
  parameter int unsigned TIMER_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  urd_in_t                       word_i,
  input  logic [SCALE_W-1:0]            range_scale_i,
  input  logic [TWIDTH_W-1:0]           trigger_width_i,
  output urd_meas_t                     meas_o,
  output logic [TIMER_BITS+SCALE_W-1:0] product_o
);

  localparam int unsigned PROD_W = TIMER_BITS + SCALE_W;

  phase_e                phase_q, phase_d;
  logic [TWIDTH_W-1:0]   trig_cnt_q, trig_cnt_d;
  logic [TIMER_BITS-1:0] timer_q, timer_d;
  logic [TIMER_BITS-1:0] rise_q, rise_d;
  logic                  clear;
  logic                  hit;
  logic [TIMER_BITS-1:0] width;

  // Sequencer next state for one step
  always_comb begin
    phase_d    = phase_q;
    trig_cnt_d = trig_cnt_q;
    rise_d     = rise_q;
    clear      = 1'b0;
    hit        = 1'b0;
    unique case (phase_q)
      PH_IDLE: begin
        if (word_i.start_req) begin
          clear      = 1'b1;
          trig_cnt_d = (trigger_width_i == '0) ? TWIDTH_W'(1) : trigger_width_i;
          phase_d    = PH_TRIG;
        end
      end
      PH_TRIG: begin
        if (trig_cnt_q <= TWIDTH_W'(1)) begin
          trig_cnt_d = '0;
          phase_d    = PH_RISE;
        end else begin
          trig_cnt_d = trig_cnt_q - TWIDTH_W'(1);
        end
      end
      PH_RISE: begin
        if (word_i.echo) begin
          rise_d  = timer_q;
          phase_d = PH_FALL;
        end
      end
      PH_FALL: begin
        if (!word_i.echo) begin
          hit     = (timer_q > rise_q);
          phase_d = PH_IDLE;
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // Echo timer wraps at its width; the start step clears it and skips the tick
  always_comb begin
    if (clear) begin
      timer_d = '0;
    end else if (word_i.count_tick) begin
      timer_d = timer_q + TIMER_BITS'(1);
    end else begin
      timer_d = timer_q;
    end
  end

  // Echo width in Q8 range units, before the shift
  assign width     = timer_q - rise_q;
  assign product_o = PROD_W'(width) * PROD_W'(range_scale_i);

  assign meas_o.trigger = (phase_d == PH_TRIG);
  assign meas_o.hit     = hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      trig_cnt_q <= '0;
      timer_q    <= '0;
      rise_q     <= '0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      trig_cnt_q <= trig_cnt_d;
      timer_q    <= timer_d;
      rise_q     <= rise_d;
    end
  end

endmodule

// ===== hw/rtl/urd_checker.sv =====
// Port-level checks for the range display block and their bind to the top level.
`timescale 1ns / 1ps

module urd_checker import urd_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input urd_out_t              out_word_o
);

  // A held result word stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  // Input side only stalls because a result is held
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // Exactly one digit is enabled
  a_one_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($countones(~out_word_o.digit_enable) == 1))
    else $error("digit enables not one-cold");

  // Every shown digit lights at least one segment
  a_seg_lit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.segments != 7'h00))
    else $error("blank segment pattern");

  // A completed measurement ends the trigger pulse
  a_hit_no_trig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.range_valid |-> !out_word_o.trigger)
    else $error("range accepted while trigger high");

endmodule

bind ultrasonic_range_display urd_checker u_urd_checker (.*);
